// ===== design/stream_find_replace_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the stream find-and-replace block
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef STREAM_FIND_REPLACE_MACROS_SVH
`define STREAM_FIND_REPLACE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define SFR_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define SFR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SFR_ASSERT(lbl, cond, msg)
`define SFR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== design/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// Stream find-and-replace package
// Shared widths, register indexes and the burst queue status type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfr_pkg;

	localparam int BYTE_W     = 8;
	localparam int LEN_W      = 4;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_BYTES      = 2'd0,
		REG_PATTERN_LENGTH     = 2'd1,
		REG_REPLACEMENT_BYTES  = 2'd2,
		REG_REPLACEMENT_LENGTH = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic             load_ready;
		logic [LEN_W-1:0] count;
	} sfr_bst_t;

endpackage

// ===== design/sfr_in_if.sv =====
// ----------------------------------------------------------------------------
// Source string channel
// Valid/ready channel that moves one source item per handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sfr_in_if import sfr_pkg::*;;
	logic              valid;
	logic              ready;
	logic              carries_byte;
	logic [BYTE_W-1:0] data_byte;
	logic              last_of_string;

	modport source(output valid, carries_byte, data_byte, last_of_string, input ready);
	modport sink(input valid, carries_byte, data_byte, last_of_string, output ready);
endinterface

// ===== design/sfr_out_if.sv =====
// ----------------------------------------------------------------------------
// Result string channel
// Valid/ready channel that moves one result item per handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sfr_out_if import sfr_pkg::*;;
	logic              valid;
	logic              ready;
	logic              byte_present;
	logic [BYTE_W-1:0] out_byte;
	logic              last_of_result;

	modport source(output valid, byte_present, out_byte, last_of_result, input ready);
	modport sink(input valid, byte_present, out_byte, last_of_result, output ready);
endinterface

// ===== design/sfr_win_cell.sv =====
// ----------------------------------------------------------------------------
// Match window cell
// Holds one window byte, takes the incoming byte when it is the append slot,
// compares against its pattern byte and shifts toward the oldest end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfr_win_cell import sfr_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic              shift,
	input  logic              wr_here,
	input  logic              active,
	input  logic [BYTE_W-1:0] in_byte,
	input  logic [BYTE_W-1:0] nxt_byte,
	input  logic [BYTE_W-1:0] pat_byte,
	output logic [BYTE_W-1:0] app_byte,
	output logic              match
);

	logic [BYTE_W-1:0] win_q;

	assign app_byte = wr_here ? in_byte : win_q;
	assign match    = !active || (app_byte == pat_byte);

	always_ff @(posedge clk) begin
		if (en) begin
			win_q <= shift ? nxt_byte : app_byte;
		end
	end

endmodule

// ===== design/sfr_burst.sv =====
// ----------------------------------------------------------------------------
// Result burst queue
// A row of byte cells loaded with all results of one item, drained one
// item per cycle into the output register unless the output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfr_burst import sfr_pkg::*; #(
	parameter  int N     = 8,
	localparam int CNT_W = $clog2(N + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              ld_valid,
	input  logic [BYTE_W-1:0] ld_bytes [N],
	input  logic [CNT_W-1:0]  ld_cnt,
	input  logic              ld_last,
	output sfr_bst_t          bst,
	sfr_out_if.source         out_str
);

	logic [BYTE_W-1:0] q_q [N];
	logic [CNT_W-1:0]  cnt_q;
	logic              last_q;
	logic              pres_q;
	logic              ov_q;
	logic              op_q;
	logic              ol_q;
	logic [BYTE_W-1:0] ob_q;
	logic              move;

	assign move           = (cnt_q != '0) && (!ov_q || out_str.ready);
	assign bst.load_ready = (cnt_q == '0) || ((cnt_q == CNT_W'(1)) && move);
	assign bst.count      = LEN_W'(cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			last_q <= 1'b0;
			pres_q <= 1'b0;
		end else if (ld_valid) begin
			if ((ld_cnt == '0) && ld_last) begin
				cnt_q  <= CNT_W'(1);
				pres_q <= 1'b0;
			end else begin
				cnt_q  <= ld_cnt;
				pres_q <= 1'b1;
			end
			last_q <= ld_last;
		end else if (move) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ld_valid) begin
			q_q <= ld_bytes;
		end else if (move) begin
			for (int k = 0; k < N - 1; k++) begin
				q_q[k] <= q_q[k + 1];
			end
			q_q[N - 1] <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (move) begin
			ov_q <= 1'b1;
		end else if (out_str.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			ob_q <= pres_q ? q_q[0] : '0;
			op_q <= pres_q;
			ol_q <= last_q && (cnt_q == CNT_W'(1));
		end
	end

	assign out_str.valid          = ov_q;
	assign out_str.byte_present   = op_q;
	assign out_str.out_byte       = ob_q;
	assign out_str.last_of_result = ol_q;

endmodule

// ===== design/stream_find_replace.sv =====
// Path: an accepted item's results are loaded into the burst queue, then moved into the output register.
// Throughput: one item per cycle while each item yields at most one result and the output is not stalled.
// An item that yields several results holds off the next item until the burst queue
// has drained down to its last result through its single output register.
// Reset: arst_n clears the configuration registers, the window count, the queue count and output valid.
// ----------------------------------------------------------------------------
// Stream find-and-replace top level
// Replaces each leftmost non-overlapping pattern match in a byte stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "stream_find_replace_macros.svh"

module stream_find_replace import sfr_pkg::*; #(
	parameter int MAX_PATTERN     = 8,
	parameter int MAX_REPLACEMENT = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	sfr_in_if.sink                in_str,
	sfr_out_if.source             out_str
);

	localparam int BURST_N = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
	localparam int PLEN_W  = $clog2(MAX_PATTERN + 1);
	localparam int RLEN_W  = $clog2(MAX_REPLACEMENT + 1);
	localparam int CNT_W   = $clog2(BURST_N + 1);

	logic [MAX_PATTERN*BYTE_W-1:0]     pat_q;
	logic [MAX_REPLACEMENT*BYTE_W-1:0] rep_q;
	logic [LEN_W-1:0]                  plen_q;
	logic [LEN_W-1:0]                  rlen_q;
	logic [PLEN_W-1:0]                 held_q;

	logic [PLEN_W-1:0] plen_e;
	logic [RLEN_W-1:0] rlen_e;
	logic [PLEN_W-1:0] held_app;
	logic              has;
	logic              last;
	logic              pass;
	logic              full;
	logic              hit;
	logic              accept;
	logic              plen_wr;

	logic [BYTE_W-1:0]      app   [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] match;
	logic [BYTE_W-1:0]      app_x [BURST_N];
	logic [BYTE_W-1:0]      rep_x [BURST_N];
	logic [BYTE_W-1:0]      ld_bytes [BURST_N];
	logic [CNT_W-1:0]       ld_cnt;
	sfr_bst_t               bst;

	assign plen_wr = cfg_we && (cfg_reg_t'(cfg_index) == REG_PATTERN_LENGTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q  <= '0;
			plen_q <= '0;
			rep_q  <= '0;
			rlen_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PATTERN_BYTES:      pat_q  <= cfg_data[MAX_PATTERN*BYTE_W-1:0];
				REG_PATTERN_LENGTH:     plen_q <= cfg_data[LEN_W-1:0];
				REG_REPLACEMENT_BYTES:  rep_q  <= cfg_data[MAX_REPLACEMENT*BYTE_W-1:0];
				REG_REPLACEMENT_LENGTH: rlen_q <= cfg_data[LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign plen_e = (plen_q > LEN_W'(MAX_PATTERN)) ? PLEN_W'(MAX_PATTERN) : plen_q[PLEN_W-1:0];
	assign rlen_e = (rlen_q > LEN_W'(MAX_REPLACEMENT)) ? RLEN_W'(MAX_REPLACEMENT)
	                                                   : rlen_q[RLEN_W-1:0];

	assign has      = in_str.carries_byte;
	assign last     = in_str.last_of_string;
	assign pass     = (plen_e == '0);
	assign held_app = held_q + PLEN_W'(has && !pass);
	assign full     = has && !pass && (held_app == plen_e);
	assign hit      = full && (&match);
	assign accept   = in_str.valid && in_str.ready;

	assign in_str.ready = bst.load_ready;

	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
		logic [BYTE_W-1:0] nxt;

		if (k == MAX_PATTERN - 1) begin : g_end
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = app[k + 1];
		end

		sfr_win_cell u_cell (
			.clk      (clk),
			.en       (accept),
			.shift    (full && !hit),
			.wr_here  (has && !pass && (held_q == PLEN_W'(k))),
			.active   (PLEN_W'(k) < plen_e),
			.in_byte  (in_str.data_byte),
			.nxt_byte (nxt),
			.pat_byte (pat_q[k*BYTE_W +: BYTE_W]),
			.app_byte (app[k]),
			.match    (match[k])
		);
	end

	for (genvar k = 0; k < BURST_N; k++) begin : g_ext
		if (k < MAX_PATTERN) begin : g_app
			assign app_x[k] = app[k];
		end else begin : g_app_pad
			assign app_x[k] = '0;
		end
		if (k < MAX_REPLACEMENT) begin : g_rep
			assign rep_x[k] = rep_q[k*BYTE_W +: BYTE_W];
		end else begin : g_rep_pad
			assign rep_x[k] = '0;
		end
	end

	always_comb begin
		for (int k = 0; k < BURST_N; k++) begin
			ld_bytes[k] = hit ? rep_x[k] : app_x[k];
		end
		if (pass) begin
			ld_bytes[0] = in_str.data_byte;
		end
		if (pass) begin
			ld_cnt = CNT_W'(has);
		end else if (hit) begin
			ld_cnt = CNT_W'(rlen_e);
		end else if (last) begin
			ld_cnt = CNT_W'(held_app);
		end else if (full) begin
			ld_cnt = CNT_W'(1);
		end else begin
			ld_cnt = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (plen_wr) begin
			held_q <= '0;
		end else if (accept) begin
			if (last || hit) begin
				held_q <= '0;
			end else if (full) begin
				held_q <= held_app - PLEN_W'(1);
			end else begin
				held_q <= held_app;
			end
		end
	end

	sfr_burst #(
		.N (BURST_N)
	) u_burst (
		.clk      (clk),
		.arst_n   (arst_n),
		.ld_valid (accept),
		.ld_bytes (ld_bytes),
		.ld_cnt   (ld_cnt),
		.ld_last  (last),
		.bst      (bst),
		.out_str  (out_str)
	);

	`SFR_ASSERT(a_held_within_pattern, held_q <= plen_e, "window holds more bytes than the pattern")
	`SFR_ASSERT(a_no_queue_overrun, !(accept && (bst.count > LEN_W'(1))), "item taken over pending results")
	`SFR_ASSERT_NEXT(a_hit_clears_window, accept && hit, held_q == '0, "window not cleared after a match")

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// Stream find-and-replace testbench
// Sends source strings through the block and compares every result item with
// a local prediction of the replaced string. A directed part covers the
// register extremes, deleted matches, empty strings and a pattern change
// while bytes are held. A random part follows, built from pattern fragments,
// with random idling on both channels and one long stall at the output.
// ----------------------------------------------------------------------------

module tb_top;
	import sfr_pkg::*;

	localparam int MAX_PAT      = 8;
	localparam int MAX_REP      = 8;
	localparam int RANDOM_ITEMS = 230;
	localparam int DRAIN_CYCLES = 10;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int LONG_HOLD    = 200;

	typedef struct {
		bit       has;
		bit [7:0] data;
		bit       last;
	} src_item_t;

	typedef struct {
		bit       present;
		bit [7:0] data;
		bit       last;
	} res_item_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	sfr_in_if  in_str();
	sfr_out_if out_str();

	stream_find_replace u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_str    (in_str),
		.out_str   (out_str)
	);

	// Predicted register contents and window state.
	bit [63:0] pat_bytes;
	bit [3:0]  pat_len;
	bit [63:0] rep_bytes;
	bit [3:0]  rep_len;
	bit [7:0]  window[MAX_PAT];
	int        held;
	int        step_results;

	src_item_t source_items[$];
	res_item_t expected_chars[$];
	int        error_count;
	int        cycle_count;
	int        tx_idle_pct = 31;
	int        rx_idle_pct = 31;
	bit        start_long_hold;
	bit        long_hold_done;
	int        hold_left;
	int        items_made;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int eff_pat_len();
		return (pat_len > MAX_PAT) ? MAX_PAT : int'(pat_len);
	endfunction

	function automatic void store_reg(cfg_reg_t idx, bit [63:0] value);
		case (idx)
			REG_PATTERN_BYTES: begin
				pat_bytes = value;
			end
			REG_PATTERN_LENGTH: begin
				pat_len = value[3:0];
				held = 0;
				foreach (window[k]) window[k] = 8'h00;
			end
			REG_REPLACEMENT_BYTES: begin
				rep_bytes = value;
			end
			REG_REPLACEMENT_LENGTH: begin
				rep_len = value[3:0];
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void emit_char(bit present, bit [7:0] data, bit last);
		res_item_t r;
		if (step_results < 8) begin
			r.present = present;
			r.data = data;
			r.last = last;
			expected_chars.push_back(r);
			step_results++;
		end
	endfunction

	function automatic void replace_predict(src_item_t it);
		int        plen;
		int        rlen;
		bit        hit;
		res_item_t r;
		plen = eff_pat_len();
		rlen = (rep_len > MAX_REP) ? MAX_REP : int'(rep_len);
		step_results = 0;
		if (held > plen)
			held = 0;
		if (it.has) begin
			if (plen == 0) begin
				emit_char(1'b1, it.data, 1'b0);
			end else begin
				window[held & 7] = it.data;
				held++;
				if (held >= plen) begin
					hit = 1'b1;
					for (int k = 0; k < plen; k++)
						if (window[k] != pat_bytes[8*k +: 8])
							hit = 1'b0;
					if (hit) begin
						for (int k = 0; k < rlen; k++)
							emit_char(1'b1, rep_bytes[8*k +: 8], 1'b0);
						held = 0;
					end else begin
						emit_char(1'b1, window[0], 1'b0);
						for (int k = 0; k + 1 < held; k++)
							window[k] = window[k + 1];
						held--;
					end
				end
			end
		end
		if (it.last) begin
			for (int k = 0; k < held && k < MAX_PAT; k++)
				emit_char(1'b1, window[k], 1'b0);
			if (step_results == 0) begin
				emit_char(1'b0, 8'h00, 1'b1);
			end else begin
				r = expected_chars.pop_back();
				r.last = 1'b1;
				expected_chars.push_back(r);
			end
			held = 0;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_str.valid <= 1'b0;
			in_str.carries_byte <= 1'b0;
			in_str.data_byte <= '0;
			in_str.last_of_string <= 1'b0;
		end else begin
			if (in_str.valid && in_str.ready) begin
				replace_predict(source_items[0]);
				void'(source_items.pop_front());
			end
			if (!in_str.valid || in_str.ready) begin
				if (source_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					in_str.valid <= 1'b1;
					in_str.carries_byte <= source_items[0].has;
					in_str.data_byte <= source_items[0].data;
					in_str.last_of_string <= source_items[0].last;
				end else begin
					in_str.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_str.ready <= 1'b0;
		end else begin
			if (start_long_hold && !long_hold_done) begin
				long_hold_done = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_str.ready <= 1'b0;
			end else begin
				out_str.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		res_item_t e;
		if (arst_n && out_str.valid && out_str.ready) begin
			if (expected_chars.size() == 0) begin
				$display("%0t: unexpected result present=%0b byte=%02h last=%0b", $time,
					out_str.byte_present, out_str.out_byte, out_str.last_of_result);
				error_count++;
			end else begin
				e = expected_chars.pop_front();
				if (out_str.byte_present !== e.present) begin
					$display("%0t: byte_present expected %0b actual %0b", $time,
						e.present, out_str.byte_present);
					error_count++;
				end
				if (out_str.out_byte !== e.data) begin
					$display("%0t: out_byte expected %02h actual %02h", $time,
						e.data, out_str.out_byte);
					error_count++;
				end
				if (out_str.last_of_result !== e.last) begin
					$display("%0t: last_of_result expected %0b actual %0b", $time,
						e.last, out_str.last_of_result);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic add_item(bit has, bit [7:0] data, bit last);
		src_item_t it;
		it.has = has;
		it.data = data;
		it.last = last;
		source_items.push_back(it);
	endtask

	task automatic write_reg(cfg_reg_t idx, bit [63:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		store_reg(idx, value);
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle();
		while (source_items.size() != 0 || expected_chars.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic bit [3:0] pick_len();
		case ($urandom_range(9))
			0: return 4'd0;
			1: return 4'd1;
			2: return 4'd8;
			3: return 4'($urandom_range(9, 15));
			default: return 4'($urandom_range(1, 8));
		endcase
	endfunction

	function automatic bit [63:0] pick_bytes();
		case ($urandom_range(9))
			0: return 64'h0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic make_string();
		int        plen;
		int        want;
		int        count;
		int        piece;
		bit [7:0]  chars[$];
		plen = eff_pat_len();
		want = $urandom_range(0, 12);
		count = 0;
		while (count < want) begin
			piece = $urandom_range(99);
			if (piece < 35 && plen > 0) begin
				for (int k = 0; k < plen; k++)
					chars.push_back(pat_bytes[8*k +: 8]);
				count += plen;
			end else if (piece < 45 && plen > 1) begin
				for (int k = 0; k < $urandom_range(1, plen - 1); k++)
					chars.push_back(pat_bytes[8*k +: 8]);
				count++;
			end else if (piece < 85) begin
				chars.push_back(pat_bytes[8*$urandom_range(0, 7) +: 8]);
				count++;
			end else begin
				chars.push_back(8'($urandom_range(0, 255)));
				count++;
			end
		end
		if (chars.size() == 0 || $urandom_range(4) == 0) begin
			foreach (chars[k])
				add_item(1'b1, chars[k], 1'b0);
			add_item(1'b0, 8'($urandom_range(0, 255)), 1'b1);
		end else begin
			foreach (chars[k])
				add_item(1'b1, chars[k], k == chars.size() - 1);
		end
		items_made += chars.size() + 1;
		if ($urandom_range(9) == 0)
			add_item(1'b0, 8'($urandom_range(0, 255)), 1'b0);
	endtask

	initial begin
		int phase;
		int phase_end;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		store_reg(REG_PATTERN_BYTES, 64'h0);
		store_reg(REG_PATTERN_LENGTH, 64'h0);
		store_reg(REG_REPLACEMENT_BYTES, 64'h0);
		store_reg(REG_REPLACEMENT_LENGTH, 64'h0);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Reset values: the pattern is empty, so bytes pass through.
		add_item(1'b1, 8'h00, 1'b0);
		add_item(1'b1, 8'hFF, 1'b1);
		add_item(1'b0, 8'h5A, 1'b1);
		add_item(1'b0, 8'hC3, 1'b0);
		add_item(1'b1, 8'hA5, 1'b1);
		wait_idle();

		write_reg(REG_PATTERN_BYTES, 64'h6261);
		write_reg(REG_PATTERN_LENGTH, 64'd2);
		write_reg(REG_REPLACEMENT_BYTES, 64'h5A5958);
		write_reg(REG_REPLACEMENT_LENGTH, 64'd3);
		end_writes();
		add_item(1'b1, 8'h78, 1'b0);
		add_item(1'b1, 8'h61, 1'b0);
		add_item(1'b1, 8'h62, 1'b0);
		add_item(1'b1, 8'h79, 1'b1);
		add_item(1'b1, 8'h61, 1'b0);
		add_item(1'b1, 8'h62, 1'b1);
		wait_idle();

		// A deleted match at the end leaves only an empty end marker.
		write_reg(REG_PATTERN_BYTES, 64'h636261);
		write_reg(REG_PATTERN_LENGTH, 64'd3);
		write_reg(REG_REPLACEMENT_LENGTH, 64'd0);
		end_writes();
		add_item(1'b1, 8'h7A, 1'b0);
		add_item(1'b1, 8'h61, 1'b0);
		add_item(1'b1, 8'h62, 1'b0);
		add_item(1'b1, 8'h63, 1'b1);
		wait_idle();

		// Oversized lengths act as the maximum.
		write_reg(REG_PATTERN_BYTES, '1);
		write_reg(REG_PATTERN_LENGTH, 64'd15);
		write_reg(REG_REPLACEMENT_BYTES, 64'h0123456789ABCDEF);
		write_reg(REG_REPLACEMENT_LENGTH, 64'd15);
		end_writes();
		for (int k = 0; k < 8; k++)
			add_item(1'b1, 8'hFF, k == 7);
		wait_idle();

		// Bytes held in the window are dropped when the pattern length changes.
		for (int k = 0; k < 3; k++)
			add_item(1'b1, 8'hFF, 1'b0);
		wait_idle();
		write_reg(REG_PATTERN_BYTES, 64'h7171);
		write_reg(REG_PATTERN_LENGTH, 64'd2);
		end_writes();
		add_item(1'b1, 8'h71, 1'b1);
		wait_idle();

		phase = 0;
		items_made = 0;
		while (items_made < RANDOM_ITEMS) begin
			write_reg(REG_PATTERN_BYTES, pick_bytes());
			write_reg(REG_PATTERN_LENGTH, 64'(pick_len()));
			write_reg(REG_REPLACEMENT_BYTES, pick_bytes());
			write_reg(REG_REPLACEMENT_LENGTH, 64'(pick_len()));
			end_writes();
			tx_idle_pct = (phase == 1 || phase == 3) ? 0 : 31;
			rx_idle_pct = (phase == 1) ? 0 : 31;
			if (phase == 3)
				start_long_hold = 1'b1;
			phase_end = items_made + 38;
			while (items_made < phase_end && items_made < RANDOM_ITEMS)
				make_string();
			wait_idle();
			phase++;
		end

		if (error_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== stream_find_replace.f =====
+incdir+design
design/sfr_pkg.sv
design/sfr_in_if.sv
design/sfr_out_if.sv
design/sfr_win_cell.sv
design/sfr_burst.sv
design/stream_find_replace.sv
tb/sv/tb_top.sv
